FILE: hw/rtl/channel_gain_offset_calibrator_core_assert.svh
// assertion macros used by the calibrator back end rtl
`ifndef CHANNEL_GAIN_OFFSET_CALIBRATOR_CORE_ASSERT_SVH
`define CHANNEL_GAIN_OFFSET_CALIBRATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CGOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CGOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cgoc_pkg.sv
package cgoc_pkg;

  localparam int CRATE_BITS = 4;
  localparam int SLOT_BITS  = 5;
  localparam int CHAN_BITS  = 6;
  localparam int KEY_BITS   = CRATE_BITS + SLOT_BITS + CHAN_BITS;
  localparam int TBL_DEPTH  = 1 << KEY_BITS;

  localparam int GAIN_W  = 24;
  localparam int VAL_W   = 32;
  localparam int ENTRY_W = 1 + GAIN_W + VAL_W;

  // multiplier: unsigned gain times 33-bit signed operand
  localparam int MULB_W = VAL_W + 1;
  localparam int PROD_W = GAIN_W + 1 + MULB_W;

  // divider
  localparam int NUM_W   = PROD_W;
  localparam int DEN_W   = GAIN_W + 8;
  localparam int DCNT_W  = $clog2(NUM_W);
  localparam int SAT_W   = NUM_W + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_UPDATE = 3'd1,
    OP_QUERY  = 3'd2,
    OP_CALIB  = 3'd3,
    OP_INV    = 3'd4
  } op_t;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [CRATE_BITS-1:0] crate_key_t;
  typedef logic [SLOT_BITS-1:0]  slot_key_t;
  typedef logic [CHAN_BITS-1:0]  chan_key_t;

  typedef struct packed {
    logic                    valid;
    logic [GAIN_W-1:0]       gain;
    logic signed [VAL_W-1:0] offset;
  } entry_t;

  // decoded word passed from front to back
  typedef struct packed {
    logic [2:0]              op;
    logic                    is_time;
    logic                    hit;
    logic signed [VAL_W-1:0] sample;
    logic [GAIN_W-1:0]       gain;
    logic signed [VAL_W-1:0] offset;
  } cmd_t;

  function automatic key_t make_key(input logic [3:0] crate, input logic [4:0] slot,
                                    input logic [5:0] chan);
    crate_key_t c;
    slot_key_t  s;
    chan_key_t  h;
    c = crate_key_t'(crate);
    s = slot_key_t'(slot);
    h = chan_key_t'(chan);
    return {c, s, h};
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
    lo = -hi - SAT_W'(1);
    if (x > hi) begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end
    return x[VAL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/cgoc_ram.sv
module cgoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: hw/rtl/cgoc_front.sv
module cgoc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        in_op,
  input  logic [3:0]        in_crate,
  input  logic [4:0]        in_slot,
  input  logic [5:0]        in_chan,
  input  logic              in_is_time,
  input  logic signed [31:0] in_sample,
  input  logic [23:0]       in_new_gain,
  input  logic signed [31:0] in_new_offset,
  output cgoc_pkg::cmd_t    cmd,
  output logic              cmd_push,
  input  logic              cmd_full
);
  import cgoc_pkg::*;

  typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_READ, F_PUSH} fstate_t;

  fstate_t                 state_r;
  key_t                    clr_cnt_r;
  key_t                    key_r;
  logic [2:0]              op_r;
  logic                    is_time_r;
  logic signed [VAL_W-1:0] sample_r;
  logic [GAIN_W-1:0]       ngain_r;
  logic signed [VAL_W-1:0] noff_r;
  cmd_t                    cmd_r;

  key_t   key;
  entry_t ent;
  entry_t wr_ent;
  logic   ram_we;
  logic   ram_re;
  key_t   ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata;

  assign key = make_key(in_crate, in_slot, in_chan);
  assign ent = entry_t'(ram_rdata);

  always_comb begin
    ram_re    = (state_r == F_IDLE) && push;
    ram_we    = 1'b0;
    ram_waddr = key_r;
    wr_ent    = '{valid: 1'b1, gain: ngain_r, offset: noff_r};
    unique case (state_r)
      F_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        wr_ent    = '0;
      end
      F_READ: begin
        ram_we = (op_r == OP_LOAD) || ((op_r == OP_UPDATE) && ent.valid);
      end
      F_IDLE, F_PUSH: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cgoc_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (key),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      unique case (state_r)
        F_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + key_t'(1);
          if (clr_cnt_r == '1) begin
            state_r <= F_IDLE;
          end
        end
        F_IDLE: begin
          if (push) begin
            key_r     <= key;
            op_r      <= in_op;
            is_time_r <= in_is_time;
            sample_r  <= in_sample;
            ngain_r   <= in_new_gain;
            noff_r    <= in_new_offset;
            state_r   <= F_READ;
          end
        end
        F_READ: begin
          cmd_r   <= '{op: op_r, is_time: is_time_r, hit: ent.valid, sample: sample_r,
                       gain: ent.gain, offset: ent.offset};
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!cmd_full) begin
            state_r <= F_IDLE;
          end
        end
      endcase
    end
  end

  assign full     = (state_r != F_IDLE);
  assign cmd_push = (state_r == F_PUSH) && !cmd_full;
  assign cmd      = cmd_r;

endmodule

FILE: hw/rtl/cgoc_fifo.sv
module cgoc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  cgoc_pkg::cmd_t wdata,
  output logic           full,
  input  logic           rd,
  output cgoc_pkg::cmd_t rdata,
  output logic           empty
);
  import cgoc_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end
  end

endmodule

FILE: hw/rtl/cgoc_back.sv
`include "channel_gain_offset_calibrator_core_assert.svh"

module cgoc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cgoc_pkg::cmd_t     cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output logic               out_found,
  output logic signed [31:0] out_result_value,
  output logic [23:0]        out_stored_gain,
  output logic signed [31:0] out_stored_offset,
  output logic               out_div_error
);
  import cgoc_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_EXEC, B_DIV} bstate_t;

  bstate_t                  state_r;
  cmd_t                     cmd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [NUM_W-1:0]         quo_r;
  logic [DEN_W:0]           rem_r;
  logic [DEN_W-1:0]         den_r;
  logic                     neg_r;
  logic [DCNT_W-1:0]        cnt_r;
  logic                     out_valid_r;
  logic                     found_r;
  logic signed [VAL_W-1:0]  res_r;
  logic [GAIN_W-1:0]        sgain_r;
  logic signed [VAL_W-1:0]  soff_r;
  logic                     derr_r;

  logic signed [VAL_W-1:0]  v;
  logic signed [VAL_W-1:0]  o;
  logic signed [MULB_W-1:0] vpo;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SAT_W-1:0]  num;
  logic signed [SAT_W-1:0]  num_mag;
  logic signed [MULB_W-1:0] trunc_sum;
  logic signed [MULB_W-1:0] zero_term;
  logic signed [VAL_W-1:0]  calib_val;
  logic signed [VAL_W-1:0]  miss_inv;
  logic [DEN_W:0]           rem_sh;
  logic                     ge;
  logic signed [SAT_W-1:0]  quo_s;

  assign v   = cmd_r.sample;
  assign o   = cmd_r.offset;
  assign vpo = MULB_W'(v) + MULB_W'(o);

  always_comb begin
    if (cmd_r.op == OP_INV) begin
      mul_b = MULB_W'(o);
    end else if (cmd_r.is_time) begin
      mul_b = MULB_W'(v);
    end else begin
      mul_b = MULB_W'(v) - MULB_W'(o);
    end
  end

  assign prod    = $signed({1'b0, cmd_r.gain}) * mul_b;
  assign prod_sh = prod_r >>> 16;

  // floor shift already done, tdc form subtracts offset afterwards
  assign calib_val = cmd_r.is_time ? sat32(SAT_W'(prod_sh) - SAT_W'(o)) : sat32(SAT_W'(prod_sh));

  // miss on inverse: integer part, rounded toward zero
  assign trunc_sum = MULB_W'(v) + ((v < 0) ? MULB_W'(255) : MULB_W'(0));
  assign miss_inv  = VAL_W'(trunc_sum >>> 8);

  assign zero_term = cmd_r.is_time ? vpo : MULB_W'(v);

  always_comb begin
    if (cmd_r.is_time) begin
      num = SAT_W'(vpo) <<< 8;
    end else begin
      num = (SAT_W'(v) <<< 16) + SAT_W'(prod_r);
    end
    num_mag = (num < 0) ? -num : num;
  end

  // one restoring step per cycle
  assign rem_sh = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});
  assign quo_s  = $signed({1'b0, quo_r[NUM_W-2:0], ge});

  assign cmd_pop = (state_r == B_IDLE) && !cmd_empty && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (cmd_pop) begin
            cmd_r   <= cmd;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prod_r  <= prod;
          state_r <= B_EXEC;
        end
        B_EXEC: begin
          found_r <= cmd_r.hit;
          res_r   <= '0;
          sgain_r <= '0;
          soff_r  <= '0;
          derr_r  <= 1'b0;
          state_r <= B_IDLE;
          out_valid_r <= 1'b1;
          priority case (cmd_r.op)
            OP_LOAD, OP_UPDATE: begin
            end
            OP_QUERY: begin
              if (cmd_r.hit) begin
                sgain_r <= cmd_r.gain;
                soff_r  <= o;
              end
            end
            OP_CALIB: begin
              res_r <= cmd_r.hit ? calib_val : v;
            end
            OP_INV: begin
              if (!cmd_r.hit) begin
                res_r <= miss_inv;
              end else if (cmd_r.gain == '0) begin
                derr_r <= 1'b1;
                if (zero_term > 0) begin
                  res_r <= {1'b0, {(VAL_W-1){1'b1}}};
                end else if (zero_term < 0) begin
                  res_r <= {1'b1, {(VAL_W-1){1'b0}}};
                end
              end else begin
                out_valid_r <= 1'b0;
                quo_r <= num_mag[NUM_W-1:0];
                rem_r <= '0;
                den_r <= cmd_r.is_time ? DEN_W'(cmd_r.gain) : {cmd_r.gain, 8'd0};
                neg_r <= (num < 0);
                cnt_r <= DCNT_W'(NUM_W - 1);
                state_r <= B_DIV;
              end
            end
            default: begin
              found_r <= 1'b0;
            end
          endcase
        end
        B_DIV: begin
          rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
          quo_r <= {quo_r[NUM_W-2:0], ge};
          cnt_r <= cnt_r - DCNT_W'(1);
          if (cnt_r == '0) begin
            res_r   <= sat32(neg_r ? -quo_s : quo_s);
            sgain_r <= '0;
            soff_r  <= '0;
            derr_r  <= 1'b0;
            found_r <= 1'b1;
            out_valid_r <= 1'b1;
            state_r <= B_IDLE;
          end
        end
      endcase
    end
  end

  assign empty             = !out_valid_r;
  assign out_found         = found_r;
  assign out_result_value  = res_r;
  assign out_stored_gain   = sgain_r;
  assign out_stored_offset = soff_r;
  assign out_div_error     = derr_r;

  `CGOC_ASSERT_NOW(a_busy_no_result, state_r != B_IDLE, !out_valid_r, "result held while busy")
  `CGOC_ASSERT_NOW(a_derr_found, out_valid_r && derr_r, found_r, "div error without hit")
  `CGOC_ASSERT_NOW(a_div_gain, state_r == B_DIV, cmd_r.gain != '0, "divide by zero gain")
  `CGOC_ASSERT_NEXT(a_pop_clears, pop && out_valid_r, !out_valid_r, "popped result stays")

endmodule

FILE: hw/rtl/channel_gain_offset_calibrator_core.sv
// per-channel gain and offset calibration table with calibrate and inverse
// input queue side: push/full, one word per op (load, update, query,
// calibrate, inverse), addressed by crate, slot and channel
// result queue side: empty/pop, exactly one result word per input word, in order
// after reset the table's valid bits are swept clear, one entry a cycle:
// full stays high until the sweep has cleared every entry; no input word is taken before that
// front: takes a word, reads the entry (registered ram read), writes the
// entry for a load or for an update that hits, and queues a decoded word;
// it takes no new word until that decoded word is queued
// back: a multiply state then a result state for most ops; an inverse that
// hits a nonzero gain runs a 58-step restoring divider, one quotient bit per
// cycle, before its result is registered
// a 2-deep queue lets the front keep taking words while the back divides or
// the result waits; if pop stays low the single result register holds its
// word, the back stalls, the queue fills and then full rises
module channel_gain_offset_calibrator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_op,
  input  logic [3:0]         in_crate,
  input  logic [4:0]         in_slot,
  input  logic [5:0]         in_chan,
  input  logic               in_is_time,
  input  logic signed [31:0] in_sample,
  input  logic [23:0]        in_new_gain,
  input  logic signed [31:0] in_new_offset,
  output logic               empty,
  input  logic               pop,
  output logic               out_found,
  output logic signed [31:0] out_result_value,
  output logic [23:0]        out_stored_gain,
  output logic signed [31:0] out_stored_offset,
  output logic               out_div_error
);
  import cgoc_pkg::*;

  // front to queue
  cmd_t q_wdata;
  logic q_wr;
  logic q_full;
  // queue to back
  cmd_t q_rdata;
  logic q_rd;
  logic q_empty;

  cgoc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_op         (in_op),
    .in_crate      (in_crate),
    .in_slot       (in_slot),
    .in_chan       (in_chan),
    .in_is_time    (in_is_time),
    .in_sample     (in_sample),
    .in_new_gain   (in_new_gain),
    .in_new_offset (in_new_offset),
    .cmd           (q_wdata),
    .cmd_push      (q_wr),
    .cmd_full      (q_full)
  );

  cgoc_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  cgoc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (q_rdata),
    .cmd_empty         (q_empty),
    .cmd_pop           (q_rd),
    .empty             (empty),
    .pop               (pop),
    .out_found         (out_found),
    .out_result_value  (out_result_value),
    .out_stored_gain   (out_stored_gain),
    .out_stored_offset (out_stored_offset),
    .out_div_error     (out_div_error)
  );

endmodule

FILE: tb/channel_gain_offset_calibrator_core_tb.sv
`timescale 1ns / 1ps

module channel_gain_offset_calibrator_core_tb;
  import cgoc_pkg::*;

  localparam int RAND_WORDS  = 1830;
  localparam int STALL_LIMIT = 200000;  // well above the valid sweep of the table after reset
  localparam int DIR_ROWS    = 20;
  localparam logic [2:0] OP_BAD = 3'd7;  // unused op code
  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [2:0] in_op;
  logic [3:0] in_crate;
  logic [4:0] in_slot;
  logic [5:0] in_chan;
  logic in_is_time;
  logic signed [31:0] in_sample, in_new_offset;
  logic [23:0] in_new_gain;
  logic out_found, out_div_error;
  logic signed [31:0] out_result_value, out_stored_offset;
  logic [23:0] out_stored_gain;

  channel_gain_offset_calibrator_core dut (.*);

  // one input word and one result word
  typedef struct {
    logic [2:0]         op;
    logic [3:0]         crate;
    logic [4:0]         slot;
    logic [5:0]         chan;
    logic               is_time;
    logic signed [31:0] sample;
    logic [23:0]        gain;
    logic signed [31:0] offset;
  } hit_word_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] value;
    logic [23:0]        gain;
    logic signed [31:0] offset;
    logic               div_err;
  } cal_word_t;

  // directed row: word plus an optional typed-in expectation
  typedef struct {
    hit_word_t w;
    logic      fixed;
    cal_word_t r;
  } dir_row_t;

  // shadow of the calibration table
  logic [23:0]        shadow_gain[int];
  logic signed [31:0] shadow_offset[int];
  cal_word_t          expected_words[$];

  int  errors = 0;
  int  words_sent = 0, words_checked = 0;
  int  idle_cycles = 0;
  bit  timed_out = 0;
  int  hits_seen = 0, div_errs_seen = 0;

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > longint'(S32_MAX)) return S32_MAX;
    if (x < longint'(S32_MIN)) return S32_MIN;
    return x[31:0];
  endfunction

  // floor of x / 2^16
  function automatic longint floor_q16(input longint x);
    return x >>> 16;
  endfunction

  // models the table and the arithmetic of one word
  function automatic cal_word_t calibrate_word(input hit_word_t w);
    cal_word_t r;
    int key;
    bit hit;
    longint g, o, v, t;
    r = '{default: '0};
    key = {w.crate[CRATE_BITS-1:0], w.slot[SLOT_BITS-1:0], w.chan[CHAN_BITS-1:0]};
    hit = shadow_gain.exists(key);
    v = longint'(w.sample);
    g = hit ? longint'({8'd0, shadow_gain[key]}) : 0;
    o = hit ? longint'(shadow_offset[key]) : 0;
    r.found = hit;
    case (w.op)
      OP_LOAD: begin
        shadow_gain[key] = w.gain;
        shadow_offset[key] = w.offset;
      end
      OP_UPDATE: if (hit) begin
        shadow_gain[key] = w.gain;
        shadow_offset[key] = w.offset;
      end
      OP_QUERY: if (hit) begin
        r.gain = shadow_gain[key];
        r.offset = shadow_offset[key];
      end
      OP_CALIB: begin
        if (!hit) r.value = w.sample;
        else if (!w.is_time) r.value = clamp32(floor_q16(g * (v - o)));
        else r.value = clamp32(floor_q16(g * v) - o);
      end
      OP_INV: begin
        if (!hit) r.value = clamp32(v / 256);
        else if (g == 0) begin
          t = w.is_time ? v + o : v;
          r.div_err = 1'b1;
          r.value = (t > 0) ? S32_MAX : (t < 0) ? S32_MIN : 32'sd0;
        end else if (!w.is_time) r.value = clamp32((v * 65536 + o * g) / (g * 256));
        else r.value = clamp32(((v + o) * 256) / g);
      end
      default: r.found = 1'b0;
    endcase
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no accepted word on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random pop gaps, compare against the oldest expectation
  initial begin
    int gap;
    cal_word_t e;
    pop = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk iff !empty);
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_found); errors++;
        end
        if (out_result_value !== e.value) begin
          $error("result_value exp %0d got %0d", e.value, out_result_value); errors++;
        end
        if (out_stored_gain !== e.gain) begin
          $error("stored_gain exp %0h got %0h", e.gain, out_stored_gain); errors++;
        end
        if (out_stored_offset !== e.offset) begin
          $error("stored_offset exp %0d got %0d", e.offset, out_stored_offset); errors++;
        end
        if (out_div_error !== e.div_err) begin
          $error("div_error exp %0d got %0d", e.div_err, out_div_error); errors++;
        end
        if (e.found) hits_seen++;
        if (e.div_err) div_errs_seen++;
        words_checked++;
      end
    end
  end

  // push one word, then record its expectation once accepted
  task automatic send_word(input hit_word_t w, input bit fixed, input cal_word_t fixed_r);
    cal_word_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_op <= w.op; in_crate <= w.crate; in_slot <= w.slot; in_chan <= w.chan;
    in_is_time <= w.is_time; in_sample <= w.sample;
    in_new_gain <= w.gain; in_new_offset <= w.offset;
    @(posedge clk iff !full);
    p = calibrate_word(w);
    if (fixed && p != fixed_r) begin
      $error("typed-in expectation disagrees with prediction, op %0d", w.op);
      errors++;
    end
    expected_words.push_back(fixed ? fixed_r : p);
    words_sent++;
  endtask

  function automatic hit_word_t mk(input logic [2:0] op, input logic [3:0] c,
                                   input logic [4:0] s, input logic [5:0] h,
                                   input logic t, input logic signed [31:0] v,
                                   input logic [23:0] g, input logic signed [31:0] o);
    hit_word_t w;
    w.op = op; w.crate = c; w.slot = s; w.chan = h; w.is_time = t;
    w.sample = v; w.gain = g; w.offset = o;
    return w;
  endfunction

  // random word: keys drawn mostly from a small pool so that hits dominate
  function automatic hit_word_t random_word();
    hit_word_t w;
    int sel;
    sel = $urandom_range(0, 99);
    w.op = (sel < 15) ? OP_LOAD : (sel < 25) ? OP_UPDATE : (sel < 40) ? OP_QUERY :
           (sel < 68) ? OP_CALIB : (sel < 97) ? OP_INV : 3'($urandom_range(5, 7));
    if ($urandom_range(0, 4) != 0) begin
      w.crate = 4'($urandom_range(0, 1)); w.slot = 5'd31; w.chan = 6'($urandom_range(0, 7));
    end else begin
      w.crate = 4'($urandom); w.slot = 5'($urandom); w.chan = 6'($urandom);
    end
    w.is_time = 1'($urandom);
    case ($urandom_range(0, 3))
      0: w.sample = $urandom;
      1: w.sample = 32'($signed(16'($urandom)));
      2: w.sample = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
      default: w.sample = 32'($signed(24'($urandom)));
    endcase
    case ($urandom_range(0, 4))
      0: w.gain = 24'd0;
      1: w.gain = 24'($urandom);
      2: w.gain = 24'hFFFFFF;
      default: w.gain = 24'($urandom_range(1, 24'h01FFFF));
    endcase
    w.offset = $urandom_range(0, 2) == 0 ? 32'($urandom) : 32'($signed(20'($urandom)));
    return w;
  endfunction

  dir_row_t dir_rows[DIR_ROWS];
  cal_word_t z;

  initial begin
    hit_word_t w;
    rst_n = 1'b0;
    push = 1'b0;
    in_op = OP_QUERY; in_crate = '0; in_slot = '0; in_chan = '0; in_is_time = 1'b0;
    in_sample = '0; in_new_gain = '0; in_new_offset = '0;
    z = '{default: '0};

    // directed table: misses on an empty table, extremes, zero gain, bad op
    dir_rows[0]  = '{mk(OP_QUERY, 4'hF, 5'h1F, 6'h3F, 0, 0, 0, 0), 1, z};
    dir_rows[1]  = '{mk(OP_CALIB, 0, 0, 0, 0, S32_MIN, 0, 0), 1,
                     '{0, S32_MIN, 0, 0, 0}};
    dir_rows[2]  = '{mk(OP_INV, 0, 0, 0, 0, -32'sd513, 0, 0), 1,
                     '{0, -32'sd2, 0, 0, 0}};
    dir_rows[3]  = '{mk(OP_UPDATE, 1, 2, 3, 0, 0, 24'h010000, 5), 1, z};
    dir_rows[4]  = '{mk(OP_LOAD, 1, 2, 3, 0, 0, 24'h010000, 32'sd256), 1, z};
    dir_rows[5]  = '{mk(OP_QUERY, 1, 2, 3, 0, 0, 0, 0), 1,
                     '{1, 0, 24'h010000, 32'sd256, 0}};
    dir_rows[6]  = '{mk(OP_CALIB, 1, 2, 3, 0, 32'sd1280, 0, 0), 1,
                     '{1, 32'sd1024, 0, 0, 0}};
    dir_rows[7]  = '{mk(OP_CALIB, 1, 2, 3, 1, 32'sd1280, 0, 0), 0, z};
    dir_rows[8]  = '{mk(OP_INV, 1, 2, 3, 0, S32_MAX, 0, 0), 0, z};
    dir_rows[9]  = '{mk(OP_INV, 1, 2, 3, 1, S32_MIN, 0, 0), 0, z};
    dir_rows[10] = '{mk(OP_UPDATE, 1, 2, 3, 0, 0, 24'hFFFFFF, S32_MIN), 0, z};
    dir_rows[11] = '{mk(OP_CALIB, 1, 2, 3, 0, S32_MAX, 0, 0), 1,
                     '{1, S32_MAX, 0, 0, 0}};
    dir_rows[12] = '{mk(OP_CALIB, 1, 2, 3, 1, S32_MIN, 0, 0), 0, z};
    dir_rows[13] = '{mk(OP_LOAD, 4'hF, 5'h1F, 6'h3F, 1, 0, 24'd0, 32'sd100), 1, z};
    dir_rows[14] = '{mk(OP_INV, 4'hF, 5'h1F, 6'h3F, 1, -32'sd100, 0, 0), 1,
                     '{1, 0, 0, 0, 1}};
    dir_rows[15] = '{mk(OP_INV, 4'hF, 5'h1F, 6'h3F, 0, -32'sd1, 0, 0), 1,
                     '{1, S32_MIN, 0, 0, 1}};
    dir_rows[16] = '{mk(OP_INV, 4'hF, 5'h1F, 6'h3F, 1, 32'sd1, 0, 0), 1,
                     '{1, S32_MAX, 0, 0, 1}};
    dir_rows[17] = '{mk(OP_LOAD, 4'hF, 5'h1F, 6'h3F, 0, 0, 24'h7FFFFF, S32_MAX), 1,
                     '{1, 0, 0, 0, 0}};
    dir_rows[18] = '{mk(OP_BAD, 4'hF, 5'h1F, 6'h3F, 1, -1, 24'hFFFFFF, -1), 1, z};
    dir_rows[19] = '{mk(3'd5, 1, 2, 3, 0, 1, 1, 1), 1, z};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].r);
    for (int i = 0; i < RAND_WORDS; i++) begin
      w = random_word();
      send_word(w, 0, z);
    end
    push <= 1'b0;

    // drain, then allow a divider's worth of extra cycles
    while (expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("tb: %0d words sent, %0d results checked", words_sent, words_checked);
    $display("tb: %0d table hits, %0d zero-gain divides", hits_seen, div_errs_seen);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
